@@ src/cave_automaton_step_assert.svh @@
// Assertion macros for the cave automaton step block.
// Used by the port-level checker; needs clk and arst_n in scope.
`ifndef CAVE_AUTOMATON_STEP_ASSERT_SVH
`define CAVE_AUTOMATON_STEP_ASSERT_SVH

// Antecedent in this cycle, consequent in the next.
`define CAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Antecedent and consequent in the same cycle.
`define CAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ src/cas_pkg.sv @@
// Shared types and constants for the cave automaton step block.
// No dependencies; used by cas_front, cas_back, the top level and the checker.
package cas_pkg;

	localparam int unsigned MAX_LINE_DEF = 128;
	localparam int unsigned OPQ_DEPTH    = 4;
	localparam int unsigned OUT_DEPTH    = 4;

	localparam int unsigned LEN_W  = 8;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned LIM_W  = 4;
	localparam int unsigned DATA_W = 16;
	localparam int unsigned POS_W  = LEN_W + CNT_W;

	localparam logic [LEN_W-1:0] LEN_RESET     = 8'd100;
	localparam logic [CNT_W-1:0] LINES_RESET   = 16'd40;
	localparam logic [LIM_W-1:0] SURVIVE_RESET = 4'd3;
	localparam logic [LIM_W-1:0] BIRTH_RESET   = 4'd4;
	localparam logic [LEN_W-1:0] LEN_MIN       = 8'd3;
	localparam logic [CNT_W-1:0] LINES_MIN     = 16'd3;

	typedef enum logic [1:0] {
		REG_LINE_LENGTH   = 2'd0,
		REG_LINE_COUNT    = 2'd1,
		REG_SURVIVE_LIMIT = 2'd2,
		REG_BIRTH_LIMIT   = 2'd3
	} cas_reg_t;

	typedef struct packed {
		logic mode;
		logic cell_wall;
	} cas_item_t;

	typedef struct packed {
		logic next_wall;
		logic frame_end;
	} cas_result_t;

	typedef struct packed {
		logic [LIM_W-1:0] survive;
		logic [LIM_W-1:0] birth;
	} cas_rules_t;

	// One shift of the stencil window, with the border flags of the cell it resolves.
	typedef struct packed {
		logic wall;
		logic emit;
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic frame_end;
	} cas_op_t;

endpackage

@@ src/cas_fifo.sv @@
// Small synchronous queue on flip-flops, first in first out.
// Depends on nothing; used for the op queue and the result queue.
module cas_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rdata,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int unsigned PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [FILL_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == FILL_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ src/cas_front.sv @@
// Front end: configuration registers, raster counters and item classification.
// Depends on cas_pkg; feeds one op per window shift into the op queue.
module cas_front #(
	parameter int unsigned MAX_LINE = cas_pkg::MAX_LINE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  cas_pkg::cas_item_t            item,
	input  logic                          wr_en,
	input  logic [1:0]                    wr_index,
	input  logic [cas_pkg::DATA_W-1:0]    wr_data,
	output logic                          hold,
	output logic                          op_push,
	output cas_pkg::cas_op_t              op,
	output logic [$clog2(MAX_LINE)-1:0]   op_addr,
	output cas_pkg::cas_rules_t           rules
);

	localparam int unsigned AW    = $clog2(MAX_LINE);
	localparam int unsigned XW    = (AW > cas_pkg::LEN_W) ? AW : cas_pkg::LEN_W;
	localparam int unsigned PW    = cas_pkg::POS_W;
	localparam int unsigned LW    = cas_pkg::LEN_W;
	localparam int unsigned HW    = cas_pkg::CNT_W;
	localparam int unsigned LCAP  = (MAX_LINE < 255) ? MAX_LINE : 255;

	logic [LW-1:0]               len_q;
	logic [HW-1:0]               lines_q;
	logic [cas_pkg::LIM_W-1:0]   survive_q;
	logic [cas_pkg::LIM_W-1:0]   birth_q;
	logic                        hold_q;
	logic [PW-1:0]               total_q;
	logic [PW-1:0]               in_pos_q;
	logic [PW-1:0]               out_pos_q;
	logic [LW-1:0]               out_col_q;
	logic [HW-1:0]               out_row_q;
	logic [AW-1:0]               sh_col_q;

	logic [LW-1:0]  len_e;
	logic [LW-1:0]  len_m1;
	logic [HW-1:0]  lines_e;
	logic [HW-1:0]  lines_m1;
	logic           wrap;
	logic [PW-1:0]  ip;
	logic [PW-1:0]  opos;
	logic [LW-1:0]  oc;
	logic [HW-1:0]  orow;
	logic           is_cell;
	logic           is_flush;
	logic [PW-1:0]  ip_n;
	logic [PW:0]    lag_mark;
	logic           emit;
	logic           first;
	logic [AW-1:0]  addr;
	logic [PW-1:0]  opos_n;
	logic [LW-1:0]  oc_n;
	logic [HW-1:0]  orow_n;
	logic           clear;

	assign hold  = hold_q;
	assign rules = '{survive: survive_q, birth: birth_q};

	// Clamp the grid dimensions to what the line memory supports.
	always_comb begin
		if (len_q < cas_pkg::LEN_MIN) begin
			len_e = cas_pkg::LEN_MIN;
		end else if (len_q > LW'(LCAP)) begin
			len_e = LW'(LCAP);
		end else begin
			len_e = len_q;
		end
		lines_e  = (lines_q < cas_pkg::LINES_MIN) ? cas_pkg::LINES_MIN : lines_q;
		len_m1   = len_e - 1'b1;
		lines_m1 = lines_e - 1'b1;
	end

	always_comb begin
		// A finished or overrun grid restarts from zero.
		wrap     = (in_pos_q >= total_q) && (out_pos_q >= total_q);
		ip       = wrap ? '0 : in_pos_q;
		opos     = wrap ? '0 : out_pos_q;
		oc       = wrap ? '0 : out_col_q;
		orow     = wrap ? '0 : out_row_q;

		is_cell  = !item.mode && (ip < total_q);
		is_flush = !is_cell && (ip >= total_q) && (opos < total_q);
		ip_n     = is_cell ? ip + 1'b1 : ip;
		lag_mark = {1'b0, opos} + (PW+1)'(len_e) + (PW+1)'(2);
		emit     = is_cell ? ({1'b0, ip_n} >= lag_mark) : is_flush;
		first    = is_cell && (ip == '0);
		addr     = first ? '0 : sh_col_q;

		opos_n = opos;
		oc_n   = oc;
		orow_n = orow;
		if (emit) begin
			opos_n = opos + 1'b1;
			if (oc >= len_m1) begin
				oc_n   = '0;
				orow_n = orow + 1'b1;
			end else begin
				oc_n = oc + 1'b1;
			end
		end
		clear = emit && (opos_n >= total_q) && (ip_n >= total_q);

		op.wall      = is_cell && item.cell_wall;
		op.emit      = emit;
		op.top       = (orow == '0);
		op.bottom    = (orow == lines_m1);
		op.left      = (oc == '0);
		op.right     = (oc == len_m1);
		op.frame_end = (orow == lines_m1) && (oc == len_m1);
	end

	assign op_push = accept && (is_cell || is_flush);
	assign op_addr = addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= cas_pkg::LEN_RESET;
			lines_q   <= cas_pkg::LINES_RESET;
			survive_q <= cas_pkg::SURVIVE_RESET;
			birth_q   <= cas_pkg::BIRTH_RESET;
			hold_q    <= 1'b0;
			total_q   <= PW'(cas_pkg::LEN_RESET) * PW'(cas_pkg::LINES_RESET);
			in_pos_q  <= '0;
			out_pos_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			sh_col_q  <= '0;
		end else begin
			hold_q  <= wr_en;
			total_q <= PW'(len_e) * PW'(lines_e);
			if (wr_en) begin
				case (wr_index)
					cas_pkg::REG_LINE_LENGTH:   len_q     <= wr_data[LW-1:0];
					cas_pkg::REG_LINE_COUNT:    lines_q   <= wr_data[HW-1:0];
					cas_pkg::REG_SURVIVE_LIMIT: survive_q <= wr_data[cas_pkg::LIM_W-1:0];
					cas_pkg::REG_BIRTH_LIMIT:   birth_q   <= wr_data[cas_pkg::LIM_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (clear) begin
					in_pos_q  <= '0;
					out_pos_q <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					in_pos_q  <= ip_n;
					out_pos_q <= opos_n;
					out_col_q <= oc_n;
					out_row_q <= orow_n;
				end
				if (is_cell || is_flush) begin
					sh_col_q <= (XW'(addr) >= XW'(len_m1)) ? '0 : addr + 1'b1;
				end
			end
		end
	end

endmodule

@@ src/cas_back.sv @@
// Back end: line memory, 3x3 stencil window and the birth / survival rule.
// Depends on cas_pkg; drains the op queue and fills the result queue.
module cas_back #(
	parameter int unsigned MAX_LINE = cas_pkg::MAX_LINE_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        op_valid,
	input  cas_pkg::cas_op_t                            op,
	input  logic [$clog2(MAX_LINE)-1:0]                 op_addr,
	output logic                                        op_take,
	input  cas_pkg::cas_rules_t                         rules,
	input  logic [$clog2(cas_pkg::OUT_DEPTH+1)-1:0]     out_count,
	output logic                                        res_push,
	output cas_pkg::cas_result_t                        res
);

	localparam int unsigned AW     = $clog2(MAX_LINE);
	localparam int unsigned FILL_W = $clog2(cas_pkg::OUT_DEPTH + 1);

	// Each entry holds {cell one line up, cell} as written one line ago.
	logic [1:0]        line_mem [MAX_LINE];
	logic [1:0]        rd_s1;
	logic              valid_s1;
	cas_pkg::cas_op_t  op_s1;
	logic [AW-1:0]     addr_s1;
	logic [5:0]        win_q;

	logic [FILL_W:0]   room_use;
	logic [2:0]        col_a;
	logic [2:0]        col_b;
	logic [2:0]        col_c;
	logic [7:0]        nb;
	logic [3:0]        walls;
	logic              center;

	// Leave room in the result queue for the op already in flight.
	assign room_use = {1'b0, out_count} + (FILL_W+1)'(valid_s1 && op_s1.emit);
	assign op_take  = op_valid && (room_use < (FILL_W+1)'(cas_pkg::OUT_DEPTH));

	always_comb begin
		// Column bits: [2] line above, [1] centre line, [0] line below.
		col_a  = win_q[5:3];
		col_b  = win_q[2:0];
		col_c  = {rd_s1[1], rd_s1[0], op_s1.wall};
		center = col_b[1];

		nb[0] = col_a[2] | op_s1.top | op_s1.left;
		nb[1] = col_b[2] | op_s1.top;
		nb[2] = col_c[2] | op_s1.top | op_s1.right;
		nb[3] = col_a[1] | op_s1.left;
		nb[4] = col_c[1] | op_s1.right;
		nb[5] = col_a[0] | op_s1.bottom | op_s1.left;
		nb[6] = col_b[0] | op_s1.bottom;
		nb[7] = col_c[0] | op_s1.bottom | op_s1.right;

		walls = '0;
		for (int i = 0; i < 8; i++) begin
			walls = walls + 4'(nb[i]);
		end

		res.next_wall = center ? (walls >= rules.survive) : (walls > rules.birth);
		res.frame_end = op_s1.frame_end;
	end

	assign res_push = valid_s1 && op_s1.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= op_take;
		end
	end

	always_ff @(posedge clk) begin
		if (op_take) begin
			rd_s1   <= line_mem[op_addr];
			op_s1   <= op;
			addr_s1 <= op_addr;
		end
		if (valid_s1) begin
			line_mem[addr_s1] <= {rd_s1[0], op_s1.wall};
			win_q             <= {col_b, col_c};
		end
	end

endmodule

@@ src/cave_automaton_step.sv @@
// Top level of the cave automaton step block: one generation of a cave cellular automaton.
// Depends on cas_pkg, cas_fifo, cas_front and cas_back.
//
// Input channel (push / full, item): cells of one grid in raster order, mode 0, then
//   flush items, mode 1, to drain the last line plus one cell of results.
// Result channel (empty / pop, result): next-generation cells in raster order;
//   frame_end marks the last cell of the grid.
// Config port (wr_en / wr_index / wr_data): line_length, line_count, survive_limit,
//   birth_limit, written while the block is idle.
// Timing: one item per cycle sustained while results are popped, set by the window
//   shift in cas_back (one line-memory read and one write each cycle, on separate
//   addresses). A result passes the op queue, the cas_back read stage and the result
//   queue, trailing its own cell by one line plus one cell. full also rises during a
//   config write and the cycle after it, while the grid size product is refreshed.
// Reset: registers return to 100 x 40, limits 3 and 4, counters and queues empty.
//   The line memory is not cleared; cells outside the grid are masked as walls.
// Stalls: when pop is held low the result queue fills, then the op queue, then full rises.
module cave_automaton_step #(
	parameter int unsigned MAX_LINE = cas_pkg::MAX_LINE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  cas_pkg::cas_item_t           item,
	output logic                         empty,
	input  logic                         pop,
	output cas_pkg::cas_result_t         result,
	input  logic                         wr_en,
	input  logic [1:0]                   wr_index,
	input  logic [cas_pkg::DATA_W-1:0]   wr_data
);

	localparam int unsigned AW     = $clog2(MAX_LINE);
	localparam int unsigned OPW    = $bits(cas_pkg::cas_op_t) + AW;
	localparam int unsigned RESW   = $bits(cas_pkg::cas_result_t);
	localparam int unsigned FILL_W = $clog2(cas_pkg::OUT_DEPTH + 1);

	logic                  accept;
	logic                  cfg_hold;
	logic                  opq_full;
	logic                  opq_empty;
	logic                  op_push;
	logic                  op_take;
	cas_pkg::cas_op_t      op_in;
	cas_pkg::cas_op_t      op_out;
	logic [AW-1:0]         addr_in;
	logic [AW-1:0]         addr_out;
	logic [OPW-1:0]        opq_rdata;
	cas_pkg::cas_rules_t   rules;
	logic                  res_push;
	cas_pkg::cas_result_t  res;
	logic [FILL_W-1:0]     out_count;
	logic [RESW-1:0]       resq_rdata;

	// Hold off items while a config write settles.
	assign full   = opq_full || cfg_hold || wr_en;
	assign accept = push && !full;

	cas_front #(
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.hold     (cfg_hold),
		.op_push  (op_push),
		.op       (op_in),
		.op_addr  (addr_in),
		.rules    (rules)
	);

	// Short op queue parts classification from the stencil.
	cas_fifo #(
		.WIDTH (OPW),
		.DEPTH (cas_pkg::OPQ_DEPTH)
	) u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  ({op_in, addr_in}),
		.pop    (op_take),
		.rdata  (opq_rdata),
		.full   (opq_full),
		.empty  (opq_empty),
		.count  ()
	);

	assign op_out   = cas_pkg::cas_op_t'(opq_rdata[OPW-1:AW]);
	assign addr_out = opq_rdata[AW-1:0];

	cas_back #(
		.MAX_LINE (MAX_LINE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (!opq_empty),
		.op        (op_out),
		.op_addr   (addr_out),
		.op_take   (op_take),
		.rules     (rules),
		.out_count (out_count),
		.res_push  (res_push),
		.res       (res)
	);

	// Result queue: the oldest result waits here until popped.
	cas_fifo #(
		.WIDTH (RESW),
		.DEPTH (cas_pkg::OUT_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.pop    (pop),
		.rdata  (resq_rdata),
		.full   (),
		.empty  (empty),
		.count  (out_count)
	);

	assign result = cas_pkg::cas_result_t'(resq_rdata);

endmodule

@@ src/cas_checker.sv @@
// Port-level checker for the cave automaton step block, bound to the top level.
// Depends on cas_pkg and cave_automaton_step_assert.svh.
`include "cave_automaton_step_assert.svh"

module cas_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  push,
	input logic                  full,
	input logic                  empty,
	input logic                  pop,
	input cas_pkg::cas_result_t  result,
	input logic                  wr_en
);

	// A waiting result holds until it is taken.
	`CAS_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result), "result changed while stalled")

	// Items are held off in the cycle after a config write.
	`CAS_ASSERT_NEXT(a_cfg_hold, wr_en, full, "item channel open right after a config write")

	// The input side cannot fill up without items arriving or a write starting.
	`CAS_ASSERT_NEXT(a_full_cause, !full && !push && !wr_en, !full || wr_en, "full rose with no item and no write")

	// Reset leaves no result waiting.
	`CAS_ASSERT_NOW(a_reset_empty, $rose(arst_n), empty, "result pending straight after reset")

endmodule

bind cave_automaton_step cas_checker u_checker (.*);
